// ----- rtl/wimp_pkg.sv -----
// Shared types, codes and helper functions for the WebAssembly import section parser.
package wimp_pkg;

  // Depth of the queue between the byte parser and the result sender.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  // Section id of the import section and the import kind codes.
  localparam logic [7:0] SecImport  = 8'h02;
  localparam logic [7:0] KindFunc   = 8'h00;
  localparam logic [7:0] KindTable  = 8'h01;
  localparam logic [7:0] KindMemory = 8'h02;
  localparam logic [7:0] KindGlobal = 8'h03;

  // LEB128 byte layout.
  localparam logic [7:0] LebPayload = 8'h7f;
  localparam int         LebStep    = 7;
  localparam logic [5:0] LebShiftMax = 6'd63;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_COUNT     = 3'd0,
    EV_MOD_BYTE  = 3'd1,
    EV_NAME_BYTE = 3'd2,
    EV_KIND      = 3'd3,
    EV_FUNC_IDX  = 3'd4,
    EV_BAD_HDR   = 3'd5,
    EV_DONE      = 3'd6,
    EV_EARLY_END = 3'd7
  } event_t;

  // Parser phases.
  typedef enum logic [4:0] {
    PH_HEADER     = 5'd0,
    PH_SEC_ID     = 5'd1,
    PH_SIZE_SKIP  = 5'd2,
    PH_SIZE_IMP   = 5'd3,
    PH_SKIP       = 5'd4,
    PH_COUNT      = 5'd5,
    PH_MOD_LEN    = 5'd6,
    PH_MOD_BYTES  = 5'd7,
    PH_NAME_LEN   = 5'd8,
    PH_NAME_BYTES = 5'd9,
    PH_KIND       = 5'd10,
    PH_FUNC_IDX   = 5'd11,
    PH_TAB_ELEM   = 5'd12,
    PH_LIM_FLAGS  = 5'd13,
    PH_LIM_INIT   = 5'd14,
    PH_LIM_MAX    = 5'd15,
    PH_GLOB_TYPE  = 5'd16,
    PH_GLOB_MUT   = 5'd17
  } phase_t;

  // One result beat.
  typedef struct packed {
    event_t      ev;
    logic [7:0]  byte_value;
    logic [31:0] import_number;
    logic [7:0]  import_kind;
    logic [31:0] number_value;
  } result_t;

  // All results caused by one input byte (one or two).
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } entry_t;

  function automatic result_t make_result(event_t ev, logic [7:0] bv, logic [31:0] inum,
                                          logic [7:0] kind, logic [31:0] num);
    result_t r;
    r.ev            = ev;
    r.byte_value    = bv;
    r.import_number = inum;
    r.import_kind   = kind;
    r.number_value  = num;
    return r;
  endfunction

  // Appends a result to the entry of the current byte.
  function automatic entry_t push_result(entry_t e, result_t r);
    entry_t o;
    o = e;
    if (e.count == 2'd0) begin
      o.r0 = r;
    end else begin
      o.r1 = r;
    end
    o.count = e.count + 2'd1;
    return o;
  endfunction

  // Expected module header: magic followed by version 1, little endian.
  function automatic logic [7:0] header_byte(logic [2:0] pos);
    logic [7:0] v;
    unique case (pos)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h61;
      3'd2:    v = 8'h73;
      3'd3:    v = 8'h6d;
      3'd4:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/wasm_import_section_parser.sv -----
// Top level of the WebAssembly import section parser.
// The parser takes one byte of a WebAssembly module per beat, checks the header, walks
// the sections to the import section and reports the import count, every module-name
// and name byte, each kind and each function type index, followed by a done, bad-header
// or ended-early event; last marks the final result of a byte. The parser accepts one
// byte every cycle while its four-entry result queue has room. A byte that causes two
// results is sent as one output beat per result, as the sender delivers one result per
// cycle while out_ready is high, so the sustained rate is one byte per cycle whenever
// the output keeps up with the results. Each result is queued when its byte is accepted.
module wasm_import_section_parser import wimp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  byte_value,
  output logic [31:0] import_number,
  output logic [7:0]  import_kind,
  output logic [31:0] number_value,
  output logic        last
);

  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  entry_t q_entry;
  entry_t q_head;

  wimp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  wimp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  wimp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .byte_value    (byte_value),
    .import_number (import_number),
    .import_kind   (import_kind),
    .number_value  (number_value),
    .last          (last)
  );

endmodule

// ----- rtl/wimp_front.sv -----
// Byte parser: header check, section walk, LEB128 decode and import entry decode.
module wimp_front import wimp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  phase_t      phase, phase_next;
  logic [2:0]  header_position, header_position_next;
  logic        header_mismatch, header_mismatch_next;
  logic [31:0] leb_accumulator, leb_accumulator_next;
  logic [5:0]  leb_shift, leb_shift_next;
  logic [31:0] imports_remaining, imports_remaining_next;
  logic [31:0] current_import, current_import_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  held_kind, held_kind_next;
  logic        has_maximum, has_maximum_next;
  logic        parse_finished, parse_finished_next;

  logic        accept;
  logic        is_leb;
  logic        end_entry;
  logic [31:0] leb_part;
  logic [31:0] leb_value;
  logic [6:0]  shift_sum;
  entry_t      ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Phases that consume a LEB128 number.
  assign is_leb = (phase == PH_SIZE_SKIP) || (phase == PH_SIZE_IMP) || (phase == PH_COUNT) ||
                  (phase == PH_MOD_LEN) || (phase == PH_NAME_LEN) || (phase == PH_FUNC_IDX) ||
                  (phase == PH_LIM_INIT) || (phase == PH_LIM_MAX);

  // Payload bits of this byte placed at the current shift; bits past 31 drop off.
  assign leb_part  = 32'(data_byte & LebPayload) << leb_shift[4:0];
  assign shift_sum = {1'b0, leb_shift} + 7'(LebStep);

  // Next state and the results of the accepted byte.
  always_comb begin
    phase_next             = phase;
    header_position_next   = header_position;
    header_mismatch_next   = header_mismatch;
    leb_accumulator_next   = leb_accumulator;
    leb_shift_next         = leb_shift;
    imports_remaining_next = imports_remaining;
    current_import_next    = current_import;
    bytes_remaining_next   = bytes_remaining;
    held_kind_next         = held_kind;
    has_maximum_next       = has_maximum;
    parse_finished_next    = parse_finished;
    end_entry              = 1'b0;
    leb_value              = leb_accumulator | leb_part;
    ent                    = '0;

    if (accept && !parse_finished) begin
      if (is_leb) begin
        if (!leb_shift[5]) begin
          leb_accumulator_next = leb_value;
        end
        leb_shift_next = shift_sum[6] ? LebShiftMax : shift_sum[5:0];
        if (!data_byte[7]) begin
          // Final LEB128 byte: act on the decoded number.
          if (leb_shift[5]) begin
            leb_value = leb_accumulator;
          end
          leb_accumulator_next = '0;
          leb_shift_next       = '0;
          unique case (phase)
            PH_SIZE_SKIP: begin
              bytes_remaining_next = leb_value;
              phase_next = (leb_value == '0) ? PH_SEC_ID : PH_SKIP;
            end
            PH_SIZE_IMP: phase_next = PH_COUNT;
            PH_COUNT: begin
              ent = push_result(ent, make_result(EV_COUNT, '0, '0, '0, leb_value));
              imports_remaining_next = leb_value;
              current_import_next    = '0;
              if (leb_value == '0) begin
                parse_finished_next = 1'b1;
                ent = push_result(ent, make_result(EV_DONE, '0, '0, '0, '0));
              end else begin
                phase_next = PH_MOD_LEN;
              end
            end
            PH_MOD_LEN: begin
              bytes_remaining_next = leb_value;
              phase_next = (leb_value == '0) ? PH_NAME_LEN : PH_MOD_BYTES;
            end
            PH_NAME_LEN: begin
              bytes_remaining_next = leb_value;
              phase_next = (leb_value == '0) ? PH_KIND : PH_NAME_BYTES;
            end
            PH_FUNC_IDX: begin
              ent = push_result(ent, make_result(EV_FUNC_IDX, '0, current_import, held_kind,
                                                 leb_value));
              end_entry = 1'b1;
            end
            PH_LIM_INIT: begin
              if (has_maximum) begin
                phase_next = PH_LIM_MAX;
              end else begin
                end_entry = 1'b1;
              end
            end
            default: end_entry = 1'b1;
          endcase
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            header_mismatch_next = header_mismatch || (data_byte != header_byte(header_position));
            if (header_position == 3'd7) begin
              if (header_mismatch_next) begin
                parse_finished_next = 1'b1;
                ent = push_result(ent, make_result(EV_BAD_HDR, '0, '0, '0, '0));
              end else begin
                phase_next = PH_SEC_ID;
              end
            end else begin
              header_position_next = header_position + 3'd1;
            end
          end
          PH_SEC_ID: phase_next = (data_byte == SecImport) ? PH_SIZE_IMP : PH_SIZE_SKIP;
          PH_SKIP: begin
            bytes_remaining_next = bytes_remaining - 32'd1;
            if (bytes_remaining == 32'd1) begin
              phase_next = PH_SEC_ID;
            end
          end
          PH_MOD_BYTES, PH_NAME_BYTES: begin
            ent = push_result(ent, make_result((phase == PH_MOD_BYTES) ? EV_MOD_BYTE
                                               : EV_NAME_BYTE, data_byte, current_import,
                                               '0, '0));
            bytes_remaining_next = bytes_remaining - 32'd1;
            if (bytes_remaining == 32'd1) begin
              phase_next = (phase == PH_MOD_BYTES) ? PH_NAME_LEN : PH_KIND;
            end
          end
          PH_KIND: begin
            held_kind_next = data_byte;
            ent = push_result(ent, make_result(EV_KIND, '0, current_import, data_byte, '0));
            priority if (data_byte == KindFunc) begin
              phase_next = PH_FUNC_IDX;
            end else if (data_byte == KindTable) begin
              phase_next = PH_TAB_ELEM;
            end else if (data_byte == KindMemory) begin
              phase_next = PH_LIM_FLAGS;
            end else if (data_byte == KindGlobal) begin
              phase_next = PH_GLOB_TYPE;
            end else begin
              end_entry = 1'b1;
            end
          end
          PH_TAB_ELEM: phase_next = PH_LIM_FLAGS;
          PH_LIM_FLAGS: begin
            has_maximum_next = data_byte[0];
            phase_next = PH_LIM_INIT;
          end
          PH_GLOB_TYPE: phase_next = PH_GLOB_MUT;
          PH_GLOB_MUT:  end_entry = 1'b1;
          default:      parse_finished_next = 1'b1;
        endcase
      end

      // Close the current import entry; the last one finishes the parse.
      if (end_entry) begin
        current_import_next    = current_import + 32'd1;
        imports_remaining_next = imports_remaining - 32'd1;
        if (imports_remaining == 32'd1) begin
          parse_finished_next = 1'b1;
          ent = push_result(ent, make_result(EV_DONE, '0, '0, '0, '0));
        end else begin
          phase_next = PH_MOD_LEN;
        end
      end
    end

    // End of the file: flag an unfinished parse and start over.
    if (accept && end_of_stream) begin
      if (!parse_finished_next) begin
        ent = push_result(ent, make_result(EV_EARLY_END, '0, '0, '0, '0));
      end
      phase_next             = PH_HEADER;
      header_position_next   = '0;
      header_mismatch_next   = 1'b0;
      leb_accumulator_next   = '0;
      leb_shift_next         = '0;
      imports_remaining_next = '0;
      current_import_next    = '0;
      bytes_remaining_next   = '0;
      held_kind_next         = '0;
      has_maximum_next       = 1'b0;
      parse_finished_next    = 1'b0;
    end
  end

  assign q_push  = accept && (ent.count != 2'd0);
  assign q_entry = ent;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_position   <= '0;
      header_mismatch   <= 1'b0;
      leb_accumulator   <= '0;
      leb_shift         <= '0;
      imports_remaining <= '0;
      current_import    <= '0;
      bytes_remaining   <= '0;
      held_kind         <= '0;
      has_maximum       <= 1'b0;
      parse_finished    <= 1'b0;
    end else begin
      phase             <= phase_next;
      header_position   <= header_position_next;
      header_mismatch   <= header_mismatch_next;
      leb_accumulator   <= leb_accumulator_next;
      leb_shift         <= leb_shift_next;
      imports_remaining <= imports_remaining_next;
      current_import    <= current_import_next;
      bytes_remaining   <= bytes_remaining_next;
      held_kind         <= held_kind_next;
      has_maximum       <= has_maximum_next;
      parse_finished    <= parse_finished_next;
    end
  end

endmodule

// ----- rtl/wimp_fifo.sv -----
// Short queue of per-byte result entries between the parser and the sender.
module wimp_fifo import wimp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  entry_t            mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr;
  logic [FifoAw-1:0] rd_ptr;
  logic [FifoAw:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (FifoAw+1)'(FifoDepth));
  assign head  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FifoAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FifoAw'(1);
      end
      count <= count + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FifoAw+1)'(FifoDepth))
    else $error("queue level above its depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from an empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.count == 2'd1 || head.count == 2'd2))
    else $error("queued entry holds no results");

endmodule

// ----- rtl/wimp_back.sv -----
// Result sender: splits each queued entry into one output beat per result.
module wimp_back import wimp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  byte_value,
  output logic [31:0] import_number,
  output logic [7:0]  import_kind,
  output logic [31:0] number_value,
  output logic        last
);

  logic    sel;
  logic    fire;
  result_t cur;

  // Current result of the head entry; the final one carries last.
  assign cur       = sel ? head.r1 : head.r0;
  assign out_valid = !empty;
  assign last      = sel || (head.count == 2'd1);
  assign fire      = out_valid && out_ready;
  assign pop       = fire && last;

  assign event_res     = cur.ev;
  assign byte_value    = cur.byte_value;
  assign import_number = cur.import_number;
  assign import_kind   = cur.import_kind;
  assign number_value  = cur.number_value;

  // Result select within the head entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (fire) begin
      sel <= !last;
    end
  end

endmodule
